>>> rtl/core/scalar_kalman_filter_macros.svh
// Assertion helpers for the scalar Kalman filter.
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SKF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skf assertion failed");

// Next-cycle implication, disabled while in reset.
`define SKF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skf assertion failed");

`endif

>>> rtl/core/skf_pkg.sv
package skf_pkg;

  // Q1.24 unity gain and rounding half
  localparam logic [24:0] ONE_Q24  = 25'd16777216;
  localparam logic [57:0] HALF_Q24 = 58'd8388608;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_VAR      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_VAR      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_ESTIMATE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VARIANCE = 4'd3;

  // Reset values
  localparam logic [31:0] MEAS_VAR_RST      = 32'd301990;
  localparam logic [31:0] PROC_VAR_RST      = 32'd838861;
  localparam logic [31:0] INIT_ESTIMATE_RST = 32'd0;
  localparam logic [31:0] INIT_VARIANCE_RST = 32'd16777216;

  typedef struct packed {
    logic signed [31:0] measurement;
    logic               restart;
  } in_data_t;

  typedef struct packed {
    logic signed [31:0] filtered_value;
    logic [31:0]        error_variance;
    logic [24:0]        kalman_gain;
  } out_data_t;

endpackage

>>> rtl/core/scalar_kalman_filter.sv
// Channel   Direction  Handshake          Content
// in_       input      in_valid/in_ready   measurement request, restart flag
// out_      output     out_valid/out_ready filtered value, variance, gain
// cfg_      input      cfg_valid/cfg_ready register index and 32-bit write data
//
// After accept, a request runs one predict step, 25 divider steps for the gain
// (one quotient bit per cycle), the two products through the shared 33x13
// multiplier with the estimate update between them, and the output register load.
// in_ready rises again in the same cycle as out_valid; cfg_ready is always high.
// Reset (rst_n low, synchronous) restores config, estimate, variance and control state.
// A result waiting on out_ready holds the last step and blocks new requests.

`include "scalar_kalman_filter_macros.svh"

module scalar_kalman_filter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  skf_pkg::in_data_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output skf_pkg::out_data_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);
  import skf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRED = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_EST  = 3'd4;
  localparam logic [2:0] ST_MUL2 = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  localparam logic [4:0] DIV_LAST = 5'd24;

  // config registers
  logic [31:0] meas_var_r, proc_var_r, init_est_r, init_var_r;

  // filter state and working registers
  logic [2:0]         state_r, state_nxt;
  logic signed [31:0] est_r, est_nxt;
  logic [31:0]        var_r, var_nxt;
  logic signed [31:0] meas_r, meas_nxt;
  logic [31:0]        p1_r, p1_nxt;
  logic [32:0]        den_r, den_nxt;
  logic [33:0]        rem_r, rem_nxt;
  logic [24:0]        gain_r, gain_nxt;
  logic [32:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [4:0]         div_cnt_r, div_cnt_nxt;
  logic [1:0]         ph_r, ph_nxt;
  logic [57:0]        acc_r, acc_nxt;
  logic [45:0]        mul_r;
  logic               out_valid_r, out_valid_nxt;
  out_data_t          out_data_r, out_data_nxt;

  // datapath temporaries
  logic [32:0]        p1_sum;
  logic [31:0]        p1_sat;
  logic signed [32:0] err;
  logic [33:0]        div_t;
  logic               div_ge;
  logic [32:0]        mul_a;
  logic [24:0]        mul_b;
  logic [12:0]        mul_chunk;
  logic [57:0]        acc_sum;
  logic [57:0]        rnd;
  logic [33:0]        corr_mag;
  logic signed [34:0] corr;
  logic signed [34:0] est_sum;

  // assertion helpers
  logic               div_busy;
  logic               rem_below;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_var_r <= MEAS_VAR_RST;
      proc_var_r <= PROC_VAR_RST;
      init_est_r <= INIT_ESTIMATE_RST;
      init_var_r <= INIT_VARIANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MEAS_VAR:      meas_var_r <= cfg_data;
        REG_PROC_VAR:      proc_var_r <= cfg_data;
        REG_INIT_ESTIMATE: init_est_r <= cfg_data;
        REG_INIT_VARIANCE: init_var_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // predict: saturated P + Q, divisor, error magnitude
  assign p1_sum = {1'b0, var_r} + {1'b0, proc_var_r};
  assign p1_sat = p1_sum[32] ? 32'hFFFF_FFFF : p1_sum[31:0];
  assign err    = {meas_r[31], meas_r} - {est_r[31], est_r};

  // restoring divider step: no shift on the first step
  assign div_t  = (div_cnt_r == 5'd0) ? rem_r : {rem_r[32:0], 1'b0};
  assign div_ge = (div_t >= {1'b0, den_r});

  // shared multiplier: operand B taken 12 low bits, then 13 high bits
  assign mul_a     = (state_r == ST_MUL2) ? {1'b0, p1_r} : mag_r;
  assign mul_b     = (state_r == ST_MUL2) ? (ONE_Q24 - gain_r) : gain_r;
  assign mul_chunk = (ph_r == 2'd0) ? {1'b0, mul_b[11:0]} : mul_b[24:12];
  assign acc_sum   = acc_r + {mul_r, 12'd0};

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_chunk;
  end

  // rounding of the correction, ties away from zero, then saturate
  assign rnd      = acc_r + HALF_Q24;
  assign corr_mag = rnd[57:24];
  assign corr     = neg_r ? -$signed({1'b0, corr_mag}) : $signed({1'b0, corr_mag});
  assign est_sum  = {{3{est_r[31]}}, est_r} + corr;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    est_nxt       = est_r;
    var_nxt       = var_r;
    meas_nxt      = meas_r;
    p1_nxt        = p1_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    gain_nxt      = gain_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    div_cnt_nxt   = div_cnt_r;
    ph_nxt        = ph_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          meas_nxt = in_data.measurement;
          if (in_data.restart) begin
            est_nxt = init_est_r;
            var_nxt = init_var_r;
          end
          state_nxt = ST_PRED;
        end
      end
      ST_PRED: begin
        p1_nxt      = p1_sat;
        den_nxt     = {1'b0, p1_sat} + {1'b0, meas_var_r};
        rem_nxt     = {2'b00, p1_sat};
        neg_nxt     = err[32];
        mag_nxt     = err[32] ? (33'd0 - err) : err;
        gain_nxt    = '0;
        div_cnt_nxt = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? (div_t - {1'b0, den_r}) : div_t;
        gain_nxt = {gain_r[23:0], div_ge};
        if (div_cnt_r == DIV_LAST) begin
          // zero divisor gives zero gain
          if (den_r == 33'd0) begin
            gain_nxt = '0;
          end
          ph_nxt    = '0;
          state_nxt = ST_MUL1;
        end else begin
          div_cnt_nxt = div_cnt_r + 5'd1;
        end
      end
      ST_MUL1, ST_MUL2: begin
        case (ph_r)
          2'd0: ph_nxt = 2'd1;
          2'd1: begin
            acc_nxt = {12'd0, mul_r};
            ph_nxt  = 2'd2;
          end
          default: begin
            acc_nxt = acc_sum;
            ph_nxt  = 2'd0;
            if (state_r == ST_MUL1) begin
              state_nxt = ST_EST;
            end else begin
              var_nxt   = acc_sum[55:24];
              state_nxt = ST_FIN;
            end
          end
        endcase
      end
      ST_EST: begin
        if (est_sum > 35'sd2147483647) begin
          est_nxt = 32'sh7FFF_FFFF;
        end else if (est_sum < -35'sd2147483648) begin
          est_nxt = 32'sh8000_0000;
        end else begin
          est_nxt = est_sum[31:0];
        end
        state_nxt = ST_MUL2;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.filtered_value = est_r;
          out_data_nxt.error_variance = var_r;
          out_data_nxt.kalman_gain    = gain_r;
          state_nxt                   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      est_r       <= INIT_ESTIMATE_RST;
      var_r       <= INIT_VARIANCE_RST;
      div_cnt_r   <= '0;
      ph_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      est_r       <= est_nxt;
      var_r       <= var_nxt;
      div_cnt_r   <= div_cnt_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    meas_r     <= meas_nxt;
    p1_r       <= p1_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    gain_r     <= gain_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  // checks
  assign div_busy  = (state_r == ST_DIV) && (div_cnt_r != 5'd0);
  assign rem_below = (rem_r < {1'b0, den_r}) || (den_r == 33'd0);

  `SKF_ASSERT_NXT(a_accept_pred, clk, rst_n, in_valid && in_ready, state_r == ST_PRED)
  `SKF_ASSERT_IMP(a_div_rem, clk, rst_n, div_busy, rem_below)
  `SKF_ASSERT_IMP(a_gain_max, clk, rst_n, out_valid_r, out_data_r.kalman_gain <= ONE_Q24)
  `SKF_ASSERT_IMP(a_rose_fin, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_FIN)

endmodule

>>> tb/tb_scalar_kalman_filter.sv
module tb_scalar_kalman_filter;
  import skf_pkg::*;

  localparam int ITEM_TOTAL = 1150;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_INIT_VARIANCE + CFG_IDX_W'(1);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_data_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_data_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // filter settings and state as the testbench tracks them
  logic [31:0] r_noise = MEAS_VAR_RST;
  logic [31:0] q_noise = PROC_VAR_RST;
  logic signed [31:0] restart_estimate = INIT_ESTIMATE_RST;
  logic [31:0] restart_variance = INIT_VARIANCE_RST;
  logic signed [31:0] est_state = '0;
  logic [31:0] var_state = INIT_VARIANCE_RST;

  out_data_t pending_estimates[$];
  int mismatch_count = 0;
  int sent_count = 0;
  logic steady = 1'b0;

  scalar_kalman_filter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // idle with a chance of roughly 8 in a hundred, never during a steady stretch
  function automatic logic idle_roll();
    return !steady && ($urandom_range(99) < 8);
  endfunction

  // one filter step: predict, gain, correct, variance update
  function automatic out_data_t filter_step(in_data_t req);
    logic [32:0] p1;
    logic [33:0] denom;
    logic [63:0] gain;
    logic [63:0] mag;
    logic [63:0] rounded;
    logic [63:0] p2;
    longint err;
    longint prod;
    longint corr;
    longint next_est;
    out_data_t res;
    if (req.restart) begin
      est_state = restart_estimate;
      var_state = restart_variance;
    end
    p1 = {1'b0, var_state} + {1'b0, q_noise};
    if (p1[32]) begin
      p1 = 33'h0_FFFF_FFFF;
    end
    denom = {1'b0, p1} + {2'b00, r_noise};
    if (denom == 0) begin
      gain = 64'd0;
    end else begin
      gain = {p1, 24'd0} / denom;
    end
    if (gain > 64'(ONE_Q24)) begin
      gain = 64'(ONE_Q24);
    end
    // correction rounds to nearest, ties away from zero
    err = longint'(req.measurement) - longint'(est_state);
    prod = longint'(gain) * err;
    mag = (prod < 0) ? 64'(-prod) : 64'(prod);
    rounded = (mag + 64'(HALF_Q24)) >> 24;
    corr = (prod < 0) ? -longint'(rounded) : longint'(rounded);
    next_est = longint'(est_state) + corr;
    if (next_est > 64'sd2147483647) begin
      next_est = 64'sd2147483647;
    end
    if (next_est < -64'sd2147483648) begin
      next_est = -64'sd2147483648;
    end
    est_state = next_est[31:0];
    p2 = ({31'd0, p1} * (64'(ONE_Q24) - gain)) >> 24;
    var_state = p2[31:0];
    res.filtered_value = est_state;
    res.error_variance = var_state;
    res.kalman_gain = gain[24:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s at %0t: got %h want %h", field, $realtime, got, want);
    mismatch_count++;
  endtask

  // output side stalls at random
  always @(posedge clk) begin
    out_ready <= !idle_roll();
  end

  // compare each result with the oldest expected one
  always @(posedge clk) begin
    out_data_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch("unexpected result", out_data.filtered_value, '0);
      end else begin
        want = pending_estimates.pop_front();
        if (out_data.filtered_value !== want.filtered_value) begin
          report_mismatch("filtered_value", out_data.filtered_value, want.filtered_value);
        end
        if (out_data.error_variance !== want.error_variance) begin
          report_mismatch("error_variance", out_data.error_variance, want.error_variance);
        end
        if (out_data.kalman_gain !== want.kalman_gain) begin
          report_mismatch("kalman_gain", 32'(out_data.kalman_gain), 32'(want.kalman_gain));
        end
      end
    end
  end

  // send one measurement request; valid stays high after acceptance
  task automatic send_measurement(input logic signed [31:0] value, input logic restart);
    in_data_t req;
    req.measurement = value;
    req.restart = restart;
    if (idle_roll()) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_estimates.push_back(filter_step(req));
    sent_count++;
  endtask

  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    if (idle_roll()) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MEAS_VAR:      r_noise = value;
      REG_PROC_VAR:      q_noise = value;
      REG_INIT_ESTIMATE: restart_estimate = value;
      REG_INIT_VARIANCE: restart_variance = value;
      default: ;
    endcase
  endtask

  // rewrite all four registers once the filter has drained
  task automatic apply_settings(input logic [31:0] r, input logic [31:0] q,
                                input logic [31:0] e0, input logic [31:0] v0);
    wait_until_idle();
    write_register(REG_MEAS_VAR, r);
    write_register(REG_PROC_VAR, q);
    write_register(REG_INIT_ESTIMATE, e0);
    write_register(REG_INIT_VARIANCE, v0);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_variance();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3: return $urandom_range(1 << 26);
      default: return $urandom_range(1 << 22);
    endcase
  endfunction

  function automatic logic [31:0] pick_estimate();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(4))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7FFF_FFFF;
      2: ;
      default: v = v >>> $urandom_range(8, 28);
    endcase
    return v;
  endfunction

  task automatic test_reset_defaults();
    send_measurement(32'sd0, 1'b0);
    send_measurement(32'sh7FFF_FFFF, 1'b0);
    send_measurement(32'sh8000_0000, 1'b0);
    send_measurement(-32'sd1, 1'b1);
    send_measurement(32'sd12345, 1'b0);
  endtask

  // R of zero: zero divisor when P1 is also zero, else unity gain
  task automatic test_zero_meas_var();
    apply_settings(32'h0, 32'h0, 32'h0001_0000, 32'h0);
    send_measurement(32'sh0005_0000, 1'b1);
    send_measurement(32'sh7FFF_FFFF, 1'b0);
    apply_settings(32'h0, PROC_VAR_RST, 32'h8000_0000, INIT_VARIANCE_RST);
    send_measurement(32'sh7FFF_FFFF, 1'b1);
    send_measurement(32'sh8000_0000, 1'b0);
  endtask

  // P + Q past the top of the range
  task automatic test_variance_saturation();
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_measurement(32'sh8000_0000, 1'b1);
    send_measurement(32'sh7FFF_FFFF, 1'b0);
    send_measurement(32'sd0, 1'b0);
  endtask

  // near-unity gain after each restart, with errors across the full range
  task automatic test_extreme_measurements();
    apply_settings(32'h1, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF);
    send_measurement(32'sh7FFF_FFFF, 1'b1);
    send_measurement(32'sh8000_0000, 1'b0);
    send_measurement(32'sh7FFF_FFFF, 1'b0);
    send_measurement(32'sd0, 1'b1);
  endtask

  // a write to an unused register index changes nothing
  task automatic test_ignored_register_index();
    wait_until_idle();
    write_register(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_FIRST_UNUSED)),
                   $urandom);
    cfg_valid <= 1'b0;
    send_measurement(32'sh0001_0000, 1'b1);
    send_measurement(-32'sh0001_0000, 1'b0);
  endtask

  // phases of settings; mostly tracking runs around a level, some noise
  task automatic test_random_tracking();
    int phase;
    int remaining;
    int seq_len;
    logic signed [31:0] level;
    logic signed [31:0] jitter;
    phase = 0;
    while (sent_count < ITEM_TOTAL) begin
      case (phase)
        0: apply_settings(MEAS_VAR_RST, PROC_VAR_RST, INIT_ESTIMATE_RST, INIT_VARIANCE_RST);
        1: apply_settings(32'h1, 32'h0, pick_estimate(), pick_variance());
        2: apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, pick_estimate(), 32'hFFFF_FFFF);
        default: apply_settings(pick_variance(), pick_variance(), pick_estimate(),
                                pick_variance());
      endcase
      steady = (phase == 3);
      remaining = $urandom_range(60, 140);
      while (remaining > 0 && sent_count < ITEM_TOTAL) begin
        if ($urandom_range(9) == 0) begin
          send_measurement($urandom, 1'($urandom_range(1)));
          remaining--;
        end else begin
          level = $urandom;
          level = level >>> $urandom_range(0, 16);
          seq_len = $urandom_range(5, 30);
          for (int i = 0; i < seq_len && remaining > 0 && sent_count < ITEM_TOTAL; i++) begin
            jitter = $urandom;
            jitter = jitter >>> $urandom_range(7, 27);
            send_measurement(level + jitter, (i == 0) || ($urandom_range(49) == 0));
            remaining--;
          end
        end
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_zero_meas_var();
    test_variance_saturation();
    test_extreme_measurements();
    test_ignored_register_index();
    test_random_tracking();
    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_estimates.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop well past the slowest passing run
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
